@@ rtl/imh_pkg.sv @@
// ----------------------------------------------------------------------------
// imh_pkg
// Types, constants and command/status records shared by the indexed heap.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int HEAP_DEPTH   = 1024;
    localparam int HANDLE_COUNT = 4096;
    localparam int KEY_WIDTH    = 32;

    localparam int SLOT_W = $clog2(HEAP_DEPTH + 1);      // slot number / count
    localparam int HND_W  = $clog2(HANDLE_COUNT + 1);    // handle number
    localparam int SADR_W = $clog2(HEAP_DEPTH + 1);      // slot memory address
    localparam int HADR_W = $clog2(HANDLE_COUNT + 1);    // handle memory address

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_PEEK   = 3'd1,
        OP_POP    = 3'd2,
        OP_DELETE = 3'd3,
        OP_CHANGE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BADH  = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]                  kind;
        logic [12:0]                 handle;
        logic signed [KEY_WIDTH-1:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic signed [KEY_WIDTH-1:0] min_key;
        logic [10:0]                 item_count;
        logic [12:0]                 assigned_handle;
        logic [1:0]                  status;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_HCHK,      // handle lookup issued
        S_HCHK2,     // handle lookup data back
        S_INS,
        S_REM_RD,    // read slot s and last slot
        S_REM_WAIT,
        S_REM_WR,
        S_CHG_WR,
        S_UP_RD,
        S_UP_WAIT,
        S_UP_SWAP,
        S_DN_RD,
        S_DN_WAIT,
        S_DN_SWAP,
        S_MIN_RD,
        S_MIN_WAIT,
        S_OUT
    } state_t;

    // command from controller to datapath
    typedef enum logic [3:0] {
        C_NONE,
        C_LATCH,     // take input item
        C_HRD,       // read handle tables at handle
        C_HSLOT,     // cursor <= handle_to_slot, register handle check
        C_INS,       // write new item into last slot
        C_REMRD,     // read cursor slot and last slot
        C_REMWR,     // move last into cursor, shrink
        C_CHGWR,     // write new key into cursor slot
        C_UPRD,      // read cursor and parent
        C_UPSWAP,    // swap cursor with parent, move up
        C_DNRD,      // read cursor and children
        C_DNSWAP,    // swap cursor with best child
        C_MINRD,     // read slot 1
        C_SETST      // set status from status code
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
        status_t   st;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic hvalid;     // handle good
        logic last_slot;  // cursor equals heap size (before shrink)
        logic cur_gone;   // cursor beyond heap after shrink
        logic up_move;    // parent greater than cursor
        logic dn_move;    // some child smaller than cursor
    } stat_t;

endpackage

@@ rtl/imh_datapath.sv @@
// ----------------------------------------------------------------------------
// imh_datapath
// Heap memories, handle tables, cursor and the compare/swap logic.
// ----------------------------------------------------------------------------
module imh_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  imh_pkg::in_item_t in_item,
    input  imh_pkg::cmd_t     cmd,
    output imh_pkg::stat_t    stat,
    output imh_pkg::out_item_t result
);
    import imh_pkg::*;

    // slot memories: key and handle, word per slot, two read ports
    logic [KEY_WIDTH-1:0] key_mem [HEAP_DEPTH+1];
    logic [HND_W-1:0]     hnd_mem [HEAP_DEPTH+1];
    // handle memories
    logic [SLOT_W-1:0]    h2s_mem [HANDLE_COUNT+1];
    logic                 live_mem [HANDLE_COUNT+1];

    in_item_t             item_reg;
    logic [SLOT_W-1:0]    size_reg, size_next;
    logic [HND_W-1:0]     issued_reg, issued_next;
    logic [SLOT_W-1:0]    cur_reg, cur_next;
    logic [1:0]           status_reg;
    logic [HND_W-1:0]     assign_reg;
    logic [KEY_WIDTH-1:0] min_reg;
    logic                 hok_reg;
    logic                 dn_phase_min;

    // live bits: handles are issued in order, so a live bit is only used
    // for handles already issued, which were set on insert; removal clears it.

    // read port registers
    logic [SADR_W-1:0]    ra_a, ra_b, ra_c;
    logic                 rd_en;
    logic [KEY_WIDTH-1:0] ka_reg, kb_reg, kc_reg;
    logic [HND_W-1:0]     ha_reg, hb_reg, hc_reg;
    logic [SLOT_W-1:0]    h2s_reg;
    logic                 live_reg;
    logic [SLOT_W-1:0]    pb_reg, pc_reg;  // addresses of read data

    logic                 kw_en, kw2_en;
    logic [SADR_W-1:0]    kw_a, kw2_a;
    logic [KEY_WIDTH-1:0] kw_d, kw2_d;
    logic [HND_W-1:0]     hw_d, hw2_d;
    logic                 h2w_en, h2w2_en, lw_en;
    logic [HADR_W-1:0]    h2w_a, h2w2_a, lw_a;
    logic [SLOT_W-1:0]    h2w_d, h2w2_d;
    logic                 lw_d;

    function automatic logic key_lt(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b);
        key_lt = $signed(a) < $signed(b);
    endfunction

    // ---------------- read addressing ----------------
    always_comb
    begin
        ra_a = cur_reg;
        ra_b = size_reg;
        ra_c = {cur_reg[SLOT_W-2:0], 1'b1};
        unique case (cmd.code)
            C_UPRD:  ra_b = {1'b0, cur_reg[SLOT_W-1:1]};
            C_DNRD:  ra_b = {cur_reg[SLOT_W-2:0], 1'b0};
            C_MINRD: ra_a = SLOT_W'(1);
            default: ;
        endcase
    end

    // read data is captured on read commands only and held for the compare
    assign rd_en = (cmd.code == C_REMRD) || (cmd.code == C_UPRD)
                || (cmd.code == C_DNRD) || (cmd.code == C_MINRD);

    // children need a third read port: the right child comes from copies
    // of the key and handle memories kept on the same write stream.
    logic [KEY_WIDTH-1:0] key_cpy [HEAP_DEPTH+1];
    logic [HND_W-1:0]     hnd_cpy [HEAP_DEPTH+1];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ka_reg <= key_mem[ra_a];
            kb_reg <= key_mem[ra_b];
            kc_reg <= key_cpy[ra_c];
            ha_reg <= hnd_mem[ra_a];
            hb_reg <= hnd_mem[ra_b];
            hc_reg <= hnd_cpy[ra_c];
            pb_reg <= ra_b;
            pc_reg <= ra_c;
        end
        h2s_reg <= h2s_mem[item_reg.handle];
        live_reg <= live_mem[item_reg.handle];
        if (kw_en)
        begin
            key_mem[kw_a] <= kw_d;
            key_cpy[kw_a] <= kw_d;
            hnd_mem[kw_a] <= hw_d;
            hnd_cpy[kw_a] <= hw_d;
        end
        if (kw2_en)
        begin
            key_mem[kw2_a] <= kw2_d;
            key_cpy[kw2_a] <= kw2_d;
            hnd_mem[kw2_a] <= hw2_d;
            hnd_cpy[kw2_a] <= hw2_d;
        end
        if (h2w_en)
            h2s_mem[h2w_a] <= h2w_d;
        if (h2w2_en)
            h2s_mem[h2w2_a] <= h2w2_d;
        if (lw_en)
            live_mem[lw_a] <= lw_d;
    end

    // ---------------- write side ----------------
    // a cursor with its top bit set has both children past the last slot
    logic lt_l, r_ok, l_ok, pick_r;
    logic [SLOT_W-1:0]    best_slot;
    logic [KEY_WIDTH-1:0] best_key;
    logic [HND_W-1:0]     best_hnd;
    always_comb
    begin
        l_ok   = !cur_reg[SLOT_W-1] && pb_reg <= size_reg;
        r_ok   = !cur_reg[SLOT_W-1] && pc_reg <= size_reg;
        lt_l   = l_ok && key_lt(kb_reg, ka_reg);
        pick_r = r_ok && (lt_l ? key_lt(kc_reg, kb_reg) : key_lt(kc_reg, ka_reg));
        best_slot = pick_r ? pc_reg : pb_reg;
        best_key  = pick_r ? kc_reg : kb_reg;
        best_hnd  = pick_r ? hc_reg : hb_reg;
    end

    logic [SLOT_W-1:0] hslot;
    always_comb
    begin
        kw_en = 1'b0; kw2_en = 1'b0; h2w_en = 1'b0; h2w2_en = 1'b0; lw_en = 1'b0;
        kw_a = cur_reg; kw2_a = pb_reg;
        kw_d = ka_reg; kw2_d = kb_reg; hw_d = ha_reg; hw2_d = hb_reg;
        h2w_a = HADR_W'(ha_reg); h2w2_a = HADR_W'(hb_reg);
        h2w_d = cur_reg; h2w2_d = pb_reg;
        lw_a = HADR_W'(item_reg.handle); lw_d = 1'b0;
        hslot = h2s_reg;
        size_next = size_reg; issued_next = issued_reg; cur_next = cur_reg;
        unique case (cmd.code)
            C_INS:
            begin
                kw_en = 1'b1; kw_a = size_reg + 1'b1;
                kw_d = item_reg.key_value; hw_d = issued_reg + 1'b1;
                h2w_en = 1'b1; h2w_a = HADR_W'(issued_reg + 1'b1);
                h2w_d = size_reg + 1'b1;
                lw_en = 1'b1; lw_a = HADR_W'(issued_reg + 1'b1); lw_d = 1'b1;
                size_next = size_reg + 1'b1; issued_next = issued_reg + 1'b1;
                cur_next = size_reg + 1'b1;
            end
            C_HSLOT: cur_next = hslot;
            C_MINRD: cur_next = SLOT_W'(1);   // pop works on the root
            C_REMWR:
            begin
                // ka/ha: cursor slot, kb/hb: last slot
                lw_en = 1'b1; lw_a = HADR_W'(ha_reg); lw_d = 1'b0;
                kw_en = 1'b1; kw_a = cur_reg; kw_d = kb_reg; hw_d = hb_reg;
                h2w_en = 1'b1; h2w_a = HADR_W'(hb_reg); h2w_d = cur_reg;
                size_next = size_reg - 1'b1;
            end
            C_CHGWR:
            begin
                kw_en = 1'b1; kw_a = cur_reg; kw_d = item_reg.key_value;
                hw_d = HND_W'(item_reg.handle);
            end
            C_UPSWAP:
            begin
                kw_en = 1'b1; kw_a = cur_reg; kw_d = kb_reg; hw_d = hb_reg;
                kw2_en = 1'b1; kw2_a = pb_reg; kw2_d = ka_reg; hw2_d = ha_reg;
                h2w_en = 1'b1; h2w_a = HADR_W'(hb_reg); h2w_d = cur_reg;
                h2w2_en = 1'b1; h2w2_a = HADR_W'(ha_reg); h2w2_d = pb_reg;
                cur_next = pb_reg;
            end
            C_DNSWAP:
            begin
                kw_en = 1'b1; kw_a = cur_reg;
                kw_d = best_key; hw_d = best_hnd;
                kw2_en = 1'b1; kw2_a = best_slot; kw2_d = ka_reg; hw2_d = ha_reg;
                h2w_en = 1'b1; h2w_a = HADR_W'(best_hnd); h2w_d = cur_reg;
                h2w2_en = 1'b1; h2w2_a = HADR_W'(ha_reg); h2w2_d = best_slot;
                cur_next = best_slot;
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= '0;
            issued_reg <= '0;
            cur_reg    <= '0;
            status_reg <= ST_OK;
            assign_reg <= '0;
            hok_reg    <= 1'b0;
        end
        else
        begin
            size_reg   <= size_next;
            issued_reg <= issued_next;
            cur_reg    <= cur_next;
            if (cmd.code == C_LATCH)
            begin
                status_reg <= ST_OK;
                assign_reg <= '0;
            end
            if (cmd.code == C_SETST)
                status_reg <= cmd.st;
            if (cmd.code == C_INS)
                assign_reg <= issued_reg + 1'b1;
            if (cmd.code == C_HSLOT || cmd.code == C_HRD)
                hok_reg <= item_reg.handle != '0
                        && {1'b0, item_reg.handle} <= {1'b0, issued_reg}
                        && live_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dn_phase_min <= 1'b0;
        else
            dn_phase_min <= (cmd.code == C_MINRD);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.code == C_LATCH)
            item_reg <= in_item;
        if (dn_phase_min)
            min_reg <= ka_reg;
    end

    // ---------------- status ----------------
    always_comb
    begin
        stat.op        = op_t'(item_reg.kind);
        stat.full      = {1'b0, size_reg} >= (SLOT_W+1)'(HEAP_DEPTH)
                      || {1'b0, issued_reg} >= (HND_W+1)'(HANDLE_COUNT);
        stat.empty     = size_reg == '0;
        stat.hvalid    = hok_reg;
        stat.last_slot = cur_reg == size_reg;
        stat.cur_gone  = {1'b0, cur_reg} > {1'b0, size_reg};
        stat.up_move   = cur_reg > SLOT_W'(1) && key_lt(ka_reg, kb_reg);
        stat.dn_move   = lt_l || pick_r;
    end

    assign result.min_key         = (size_reg == '0) ? '0 : min_reg;
    assign result.item_count      = 11'(size_reg);
    assign result.assigned_handle = 13'(assign_reg);
    assign result.status          = status_reg;

endmodule

@@ rtl/imh_ctrl.sv @@
// ----------------------------------------------------------------------------
// imh_ctrl
// Operation sequencer: decode, handle check, insert/remove, sift up/down.
// ----------------------------------------------------------------------------
module imh_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  imh_pkg::stat_t stat,
    output imh_pkg::cmd_t  cmd
);
    import imh_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.code    = C_NONE;
        cmd.st      = ST_OK;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.code   = C_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op) inside
                    OP_INSERT:
                        if (stat.full)
                        begin
                            cmd.code = C_SETST; cmd.st = ST_FULL;
                            state_next = S_MIN_RD;
                        end
                        else
                        begin
                            cmd.code = C_INS;
                            state_next = S_UP_RD;
                        end
                    OP_PEEK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.code = C_SETST; cmd.st = ST_EMPTY;
                        end
                        state_next = S_MIN_RD;
                    end
                    OP_POP:
                        if (stat.empty)
                        begin
                            cmd.code = C_SETST; cmd.st = ST_EMPTY;
                            state_next = S_MIN_RD;
                        end
                        else
                        begin
                            cmd.code = C_MINRD;   // cursor to slot 1
                            state_next = S_REM_RD;
                        end
                    OP_DELETE, OP_CHANGE:
                    begin
                        cmd.code = C_HRD;
                        state_next = S_HCHK;
                    end
                    default: state_next = S_MIN_RD;
                endcase
            end
            S_HCHK:
            begin
                cmd.code = C_HSLOT;
                state_next = S_HCHK2;
            end
            S_HCHK2:
                if (!stat.hvalid)
                begin
                    cmd.code = C_SETST; cmd.st = ST_BADH;
                    state_next = S_MIN_RD;
                end
                else if (stat.op == OP_CHANGE)
                    state_next = S_CHG_WR;
                else
                    state_next = S_REM_RD;
            S_REM_RD:
            begin
                cmd.code = C_REMRD;
                state_next = S_REM_WAIT;
            end
            S_REM_WAIT: state_next = S_REM_WR;
            S_REM_WR:
            begin
                cmd.code = C_REMWR;
                state_next = S_INS;
            end
            S_INS:
                state_next = stat.cur_gone ? S_MIN_RD : S_UP_RD;
            S_CHG_WR:
            begin
                cmd.code = C_CHGWR;
                state_next = S_UP_RD;
            end
            S_UP_RD:
            begin
                cmd.code = C_UPRD;
                state_next = S_UP_WAIT;
            end
            S_UP_WAIT: state_next = S_UP_SWAP;
            S_UP_SWAP:
                if (stat.up_move)
                begin
                    cmd.code = C_UPSWAP;
                    state_next = S_UP_RD;
                end
                else
                    state_next = S_DN_RD;
            S_DN_RD:
            begin
                cmd.code = C_DNRD;
                state_next = S_DN_WAIT;
            end
            S_DN_WAIT: state_next = S_DN_SWAP;   // read data held for compare
            S_DN_SWAP:
                if (stat.dn_move)
                begin
                    cmd.code = C_DNSWAP;
                    state_next = S_DN_RD;
                end
                else
                    state_next = S_MIN_RD;
            S_MIN_RD:
            begin
                cmd.code = C_MINRD;
                state_next = S_MIN_WAIT;
            end
            S_MIN_WAIT: state_next = S_OUT;
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ rtl/indexed_min_heap_top.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap_top
// Indexed binary min-heap with handles: insert, peek, pop, delete, change.
// ----------------------------------------------------------------------------
// Latency (input transfer to result) depends on the op and grows with each
// heap level moved by a sift. Throughput: one item at a time; the next input
// is taken in the cycle after the result transfer, and the sift loop (read,
// wait, compare/swap per level) sets how long an op runs.
// Reset: heap empty, no handles issued; memories keep garbage, never used
// before written.
// ----------------------------------------------------------------------------
module indexed_min_heap_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  imh_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output imh_pkg::out_item_t  out_data
);
    import imh_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: one transfer in, runs the op, one transfer out
    imh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // memories and heap bookkeeping
    imh_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (out_data)
    );

    // never accept while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result dropped under stall");

    // count never exceeds depth
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.item_count <= 11'(HEAP_DEPTH))
        else $error("item count overflow");

endmodule
